// ----- rtl/timed_history_ring_lookup_macros.svh -----
// assertion macros shared by the checker
`ifndef TIMED_HISTORY_RING_LOOKUP_MACROS_SVH
`define TIMED_HISTORY_RING_LOOKUP_MACROS_SVH

// same-cycle implication, masked during reset
`define THRL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define THRL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds through reset
`define THRL_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/thrl_pkg.sv -----
`timescale 1ns / 1ps
package thrl_pkg;

   localparam int NUM_RINGS_DEF  = 4;
   localparam int RING_SLOTS_DEF = 64;
   localparam int NUM_CFG        = 4;
   localparam int CFG_IDX_W      = 2;
   localparam int WIN_W          = 40;
   localparam int STAMP_W        = 48;
   localparam int VAL_W          = 32;
   localparam int NUM_VALS       = 6;
   localparam int FRAC_W         = 17;
   localparam logic [WIN_W-1:0] WINDOW_RESET = 40'd1000000;

   localparam logic [1:0] CMD_RECORD = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   typedef enum logic [1:0] {
      KIND_RECORD,
      KIND_READ,
      KIND_CLEAR,
      KIND_REJECT
   } kind_type;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [2:0]               ring_sel;
      logic [STAMP_W-1:0]       stamp;
      logic signed [VAL_W-1:0]  pos_x;
      logic signed [VAL_W-1:0]  pos_y;
      logic signed [VAL_W-1:0]  pos_z;
      logic signed [VAL_W-1:0]  scl_x;
      logic signed [VAL_W-1:0]  scl_y;
      logic signed [VAL_W-1:0]  scl_z;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic [STAMP_W-1:0]       out_stamp;
      logic signed [VAL_W-1:0]  out_pos_x;
      logic signed [VAL_W-1:0]  out_pos_y;
      logic signed [VAL_W-1:0]  out_pos_z;
      logic signed [VAL_W-1:0]  out_scl_x;
      logic signed [VAL_W-1:0]  out_scl_y;
      logic signed [VAL_W-1:0]  out_scl_z;
   } rsp_type;

   typedef struct packed {
      kind_type kind;
      req_type  req;
   } job_type;

endpackage

// ----- rtl/timed_history_ring_lookup.sv -----
// sequence: clear, rejected and same-time record go from EXEC to DONE; other records may
//   then trim through TRIM_RD/TRIM_CK; reads search, divide and interpolate where needed
// throughput: one transaction in the engine at a time, set by the sample memory
//   read port walked by trim and search, the 17-step divider and the shared multiplier
// reset: rings emptied, windows back to 1000000 ticks, queues empty; sample memory
//   is not cleared and needs no clearing pass
`timescale 1ns / 1ps
module timed_history_ring_lookup #(
   parameter int NUM_RINGS  = thrl_pkg::NUM_RINGS_DEF,
   parameter int RING_SLOTS = thrl_pkg::RING_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request side, queue-like
   input  logic                              push,
   output logic                              full,
   input  thrl_pkg::req_type                 req_payload,
   // response side, queue-like
   output logic                              empty,
   input  logic                              pop,
   output thrl_pkg::rsp_type                 rsp_payload,
   // window registers
   input  logic                              csr_wr_en,
   input  logic [thrl_pkg::CFG_IDX_W-1:0]    csr_index,
   input  logic [thrl_pkg::WIN_W-1:0]        csr_wdata
);
   // history windows, one register per ring up to NUM_CFG-1; rings past NUM_CFG-1 share the last one
   logic [thrl_pkg::NUM_CFG-1:0][thrl_pkg::WIN_W-1:0] win_ff, win_in;

   // hand-off between front queue and engine
   logic              job_valid;
   logic              job_pop;
   thrl_pkg::job_type job;

   always_comb begin
      win_in = win_ff;
      if (csr_wr_en) begin
         win_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < thrl_pkg::NUM_CFG; k++) begin
            win_ff[k] <= thrl_pkg::WINDOW_RESET;
         end
      end else begin
         win_ff <= win_in;
      end
   end

   // front: two-deep queue, each transaction tagged record/read/clear/reject
   thrl_front #(.NUM_RINGS(NUM_RINGS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_payload (req_payload),
      .job_valid   (job_valid),
      .job         (job),
      .job_pop     (job_pop)
   );

   // back: ring bookkeeping, sample memory, search, divide, interpolate,
   // and a two-deep result queue so the engine can finish a transaction
   // while an earlier result still waits
   thrl_back #(.NUM_RINGS(NUM_RINGS), .RING_SLOTS(RING_SLOTS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .windows     (win_ff),
      .job_valid   (job_valid),
      .job         (job),
      .job_pop     (job_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp_payload (rsp_payload)
   );
endmodule

// ----- rtl/thrl_ram.sv -----
`timescale 1ns / 1ps
module thrl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/thrl_front.sv -----
`timescale 1ns / 1ps
module thrl_front #(
   parameter int NUM_RINGS = thrl_pkg::NUM_RINGS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  thrl_pkg::req_type req_payload,
   output logic              job_valid,
   output thrl_pkg::job_type job,
   input  logic              job_pop
);
   thrl_pkg::job_type q_ff [2];
   logic              wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]        cnt_ff, cnt_in;
   thrl_pkg::kind_type kind;
   logic              take;
   logic              ring_ok;

   always_comb begin
      ring_ok = 32'(req_payload.ring_sel) < NUM_RINGS;
      unique case (req_payload.cmd)
         thrl_pkg::CMD_CLEAR:  kind = thrl_pkg::KIND_CLEAR;
         thrl_pkg::CMD_RECORD: kind = ring_ok ? thrl_pkg::KIND_RECORD : thrl_pkg::KIND_REJECT;
         thrl_pkg::CMD_READ:   kind = ring_ok ? thrl_pkg::KIND_READ : thrl_pkg::KIND_REJECT;
         default:              kind = thrl_pkg::KIND_REJECT;
      endcase
   end

   assign full      = (cnt_ff == 2'd2);
   assign take      = push && !full;
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rd_ff];

   always_comb begin
      wr_in  = take ? ~wr_ff : wr_ff;
      rd_in  = (job_pop && job_valid) ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(take) - 2'(job_pop && job_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (take) begin
         q_ff[wr_ff] <= '{kind: kind, req: req_payload};
      end
   end
endmodule

// ----- rtl/thrl_back.sv -----
`timescale 1ns / 1ps
module thrl_back #(
   parameter int NUM_RINGS  = thrl_pkg::NUM_RINGS_DEF,
   parameter int RING_SLOTS = thrl_pkg::RING_SLOTS_DEF
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic [thrl_pkg::NUM_CFG-1:0][thrl_pkg::WIN_W-1:0]   windows,
   input  logic                                                job_valid,
   input  thrl_pkg::job_type                                   job,
   output logic                                                job_pop,
   output logic                                                empty,
   input  logic                                                pop,
   output thrl_pkg::rsp_type                                   rsp_payload
);
   localparam int RW    = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
   localparam int SW    = $clog2(RING_SLOTS);
   localparam int FW    = $clog2(RING_SLOTS + 1);
   localparam int DEPTH = NUM_RINGS * RING_SLOTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int TW    = thrl_pkg::STAMP_W;
   localparam int VL    = thrl_pkg::VAL_W;
   localparam int VW    = thrl_pkg::NUM_VALS * VL;
   localparam int QW    = thrl_pkg::FRAC_W;
   localparam int PW    = VL + 1 + QW + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_TRIM_RD, ST_TRIM_CK, ST_RD_OLD, ST_BS_RD, ST_BS_CK,
      ST_LD_ONE, ST_LD_A, ST_LD_B, ST_DIV, ST_MUL, ST_ADD, ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   thrl_pkg::job_type  job_ff, job_in;
   logic [SW-1:0]      head_ff [NUM_RINGS];
   logic [SW-1:0]      head_in [NUM_RINGS];
   logic [FW-1:0]      fill_ff [NUM_RINGS];
   logic [FW-1:0]      fill_in [NUM_RINGS];
   logic [TW-1:0]      newest_ff [NUM_RINGS];
   logic [TW-1:0]      newest_in [NUM_RINGS];
   logic [TW-1:0]      cut_ff, cut_in;
   logic [SW-1:0]      lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [TW-1:0]      ta_ff, ta_in, den_ff, den_in, rem_ff, rem_in;
   logic [VW-1:0]      va_ff, va_in, vb_ff, vb_in;
   logic [QW-1:0]      quo_ff, quo_in;
   logic [4:0]         div_cnt_ff, div_cnt_in;
   logic [2:0]         lane_ff, lane_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic               ok_ff, ok_in;
   logic [VL-1:0]      res_ff [thrl_pkg::NUM_VALS];
   logic [VL-1:0]      res_in [thrl_pkg::NUM_VALS];

   thrl_pkg::rsp_type  oq_ff [2];
   logic               oq_wr_ff, oq_wr_in, oq_rd_ff, oq_rd_in;
   logic [1:0]         oq_cnt_ff, oq_cnt_in;
   logic               oq_push;
   thrl_pkg::rsp_type  rsp_new;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr, rd_addr;
   logic [TW-1:0]      time_wdata, time_rd;
   logic [VW-1:0]      val_wdata, val_rd;

   logic [RW-1:0]      ring;
   logic [TW-1:0]      stamp;

   function automatic logic [SW-1:0] inc_wrap(input logic [SW-1:0] h);
      return (h == SW'(RING_SLOTS - 1)) ? '0 : h + 1'b1;
   endfunction

   function automatic logic [AW-1:0] slot_addr(input logic [RW-1:0] r,
                                                input logic [SW-1:0] h,
                                                input logic [SW-1:0] i);
      logic [SW:0] s;
      s = {1'b0, h} + {1'b0, i};
      if (s >= (SW+1)'(RING_SLOTS)) begin
         s = s - (SW+1)'(RING_SLOTS);
      end
      return AW'(32'(r) * RING_SLOTS) + AW'(s);
   endfunction

   assign ring  = job_ff.req.ring_sel[RW-1:0];
   assign stamp = job_ff.req.stamp;

   thrl_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_time_ram (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(time_wdata),
      .rd_addr(rd_addr), .rd_data(time_rd)
   );

   thrl_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_val_ram (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(val_wdata),
      .rd_addr(rd_addr), .rd_data(val_rd)
   );

   assign time_wdata = stamp;
   assign val_wdata  = {job_ff.req.scl_z, job_ff.req.scl_y, job_ff.req.scl_x,
                        job_ff.req.pos_z, job_ff.req.pos_y, job_ff.req.pos_x};

   always_comb begin
      rsp_new.ok        = ok_ff;
      rsp_new.out_stamp = (ok_ff && job_ff.kind == thrl_pkg::KIND_READ) ? stamp : '0;
      rsp_new.out_pos_x = res_ff[0];
      rsp_new.out_pos_y = res_ff[1];
      rsp_new.out_pos_z = res_ff[2];
      rsp_new.out_scl_x = res_ff[3];
      rsp_new.out_scl_y = res_ff[4];
      rsp_new.out_scl_z = res_ff[5];
   end

   always_comb begin
      logic [FW-1:0]       f;
      logic [SW-1:0]       h;
      logic [thrl_pkg::WIN_W-1:0] win;
      logic [SW:0]         msum;
      logic [TW:0]         trial;
      logic signed [VL:0]  diff;
      logic [VL-1:0]       a_val;

      state_in   = state_ff;
      job_in     = job_ff;
      head_in    = head_ff;
      fill_in    = fill_ff;
      newest_in  = newest_ff;
      cut_in     = cut_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      ta_in      = ta_ff;
      den_in     = den_ff;
      rem_in     = rem_ff;
      va_in      = va_ff;
      vb_in      = vb_ff;
      quo_in     = quo_ff;
      div_cnt_in = div_cnt_ff;
      lane_in    = lane_ff;
      prod_in    = prod_ff;
      ok_in      = ok_ff;
      res_in     = res_ff;
      job_pop    = 1'b0;
      oq_push    = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      rd_addr    = '0;

      f     = fill_ff[ring];
      h     = head_ff[ring];
      win   = (32'(ring) < thrl_pkg::NUM_CFG) ? windows[thrl_pkg::CFG_IDX_W'(ring)]
                                              : windows[thrl_pkg::NUM_CFG-1];
      msum  = {1'b0, lo_ff} + {1'b0, hi_ff};
      trial = (div_cnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      a_val = va_ff[lane_ff*VL +: VL];
      diff  = $signed({vb_ff[lane_ff*VL + VL - 1], vb_ff[lane_ff*VL +: VL]})
            - $signed({a_val[VL-1], a_val});

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in   = job;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ok_in = 1'b0;
            for (int k = 0; k < thrl_pkg::NUM_VALS; k++) begin
               res_in[k] = '0;
            end
            state_in = ST_DONE;
            unique case (job_ff.kind)
               thrl_pkg::KIND_CLEAR: begin
                  for (int k = 0; k < NUM_RINGS; k++) begin
                     head_in[k] = '0;
                     fill_in[k] = '0;
                  end
                  ok_in = 1'b1;
               end
               thrl_pkg::KIND_RECORD: begin
                  ok_in = 1'b1;
                  if (f != '0 && stamp == newest_ff[ring]) begin
                     mem_we    = 1'b1;
                     mem_waddr = slot_addr(ring, h, SW'(f - 1'b1));
                  end else begin
                     if (f != '0 && stamp < newest_ff[ring]) begin
                        h = '0;
                        f = '0;
                     end
                     if (f == FW'(RING_SLOTS)) begin
                        h = inc_wrap(h);
                        f = FW'(RING_SLOTS - 1);
                     end
                     mem_we          = 1'b1;
                     mem_waddr       = slot_addr(ring, h, SW'(f));
                     head_in[ring]   = h;
                     fill_in[ring]   = f + 1'b1;
                     newest_in[ring] = stamp;
                     cut_in          = stamp - TW'(win);
                     if (TW'(win) <= stamp) begin
                        state_in = ST_TRIM_RD;
                     end
                  end
               end
               thrl_pkg::KIND_READ: begin
                  if (f == '0 || stamp > newest_ff[ring]) begin
                     state_in = ST_DONE;
                  end else if (stamp == newest_ff[ring]) begin
                     rd_addr  = slot_addr(ring, h, SW'(f - 1'b1));
                     state_in = ST_LD_ONE;
                  end else begin
                     rd_addr  = slot_addr(ring, h, '0);
                     state_in = ST_RD_OLD;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_TRIM_RD: begin
            if (f >= FW'(2)) begin
               rd_addr  = slot_addr(ring, h, SW'(1));
               state_in = ST_TRIM_CK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TRIM_CK: begin
            if (time_rd <= cut_ff) begin
               head_in[ring] = inc_wrap(h);
               fill_in[ring] = f - 1'b1;
               state_in      = ST_TRIM_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RD_OLD: begin
            if (stamp < time_rd) begin
               state_in = ST_DONE;
            end else begin
               lo_in    = '0;
               hi_in    = SW'(f - 1'b1);
               state_in = ST_BS_RD;
            end
         end
         ST_BS_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in   = msum[SW:1];
               rd_addr  = slot_addr(ring, h, msum[SW:1]);
               state_in = ST_BS_CK;
            end else if (lo_ff == '0) begin
               rd_addr  = slot_addr(ring, h, '0);
               state_in = ST_LD_ONE;
            end else begin
               rd_addr  = slot_addr(ring, h, lo_ff - 1'b1);
               state_in = ST_LD_A;
            end
         end
         ST_BS_CK: begin
            if (time_rd < stamp) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_BS_RD;
         end
         ST_LD_ONE: begin
            for (int k = 0; k < thrl_pkg::NUM_VALS; k++) begin
               res_in[k] = val_rd[k*VL +: VL];
            end
            ok_in    = 1'b1;
            state_in = ST_DONE;
         end
         ST_LD_A: begin
            ta_in    = time_rd;
            va_in    = val_rd;
            rd_addr  = slot_addr(ring, h, lo_ff);
            state_in = ST_LD_B;
         end
         ST_LD_B: begin
            vb_in      = val_rd;
            den_in     = time_rd - ta_ff;
            rem_in     = stamp - ta_ff;
            quo_in     = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            // one quotient bit per cycle, top bit first
            if (trial >= {1'b0, den_ff}) begin
               rem_in = TW'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = TW'(trial);
               quo_in = {quo_ff[QW-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == 5'(QW - 1)) begin
               lane_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = diff * $signed({1'b0, quo_ff});
            state_in = ST_ADD;
         end
         ST_ADD: begin
            // arithmetic shift floors toward minus infinity
            res_in[lane_ff] = a_val + prod_ff[16 +: VL];
            if (lane_ff == 3'(thrl_pkg::NUM_VALS - 1)) begin
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end else begin
               lane_in  = lane_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (oq_cnt_ff != 2'd2) begin
               oq_push  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign empty       = (oq_cnt_ff == 2'd0);
   assign rsp_payload = oq_ff[oq_rd_ff];

   always_comb begin
      oq_wr_in  = oq_push ? ~oq_wr_ff : oq_wr_ff;
      oq_rd_in  = (pop && !empty) ? ~oq_rd_ff : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff + 2'(oq_push) - 2'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
         for (int k = 0; k < NUM_RINGS; k++) begin
            head_ff[k] <= '0;
            fill_ff[k] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
         head_ff   <= head_in;
         fill_ff   <= fill_in;
      end
      job_ff     <= job_in;
      newest_ff  <= newest_in;
      cut_ff     <= cut_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      ta_ff      <= ta_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      va_ff      <= va_in;
      vb_ff      <= vb_in;
      quo_ff     <= quo_in;
      div_cnt_ff <= div_cnt_in;
      lane_ff    <= lane_in;
      prod_ff    <= prod_in;
      ok_ff      <= ok_in;
      res_ff     <= res_in;
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= rsp_new;
      end
   end
endmodule

// ----- rtl/thrl_checker.sv -----
`timescale 1ns / 1ps
`include "timed_history_ring_lookup_macros.svh"
module thrl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           full,
   input logic                           empty,
   input logic                           pop,
   input thrl_pkg::rsp_type              rsp_payload
);
   `THRL_ASSERT_RESET(a_reset_clears, reset, empty && !full, "queues not empty after reset")
   `THRL_ASSERT_SAME(a_fail_zero, !empty && !rsp_payload.ok, rsp_payload.out_stamp == '0 && rsp_payload.out_pos_x == '0 && rsp_payload.out_scl_z == '0, "failed transaction carries data")
   `THRL_ASSERT_NEXT(a_rsp_hold, !empty && !pop, !empty && $stable(rsp_payload), "waiting response changed")
endmodule

bind timed_history_ring_lookup thrl_checker u_thrl_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import thrl_pkg::*;

   localparam int RINGS = NUM_RINGS_DEF;
   localparam int SLOTS = RING_SLOTS_DEF;
   localparam int RANDOM_ITEMS = 1350;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   req_type req_payload = '0;
   logic empty;
   logic pop = 1'b0;
   rsp_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [CFG_IDX_W-1:0] csr_index = '0;
   logic [WIN_W-1:0] csr_wdata = '0;

   timed_history_ring_lookup u_dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_payload(req_payload),
      .empty(empty), .pop(pop), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state: per-ring sample history and window registers
   logic [STAMP_W-1:0] hist_time [RINGS][SLOTS];
   logic [VAL_W-1:0]   hist_val  [RINGS][SLOTS][NUM_VALS];
   int                 hist_head [RINGS];
   int                 hist_fill [RINGS];
   logic [WIN_W-1:0]   window_shadow [NUM_CFG];

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      errors = 0;
   longint  cycle_count = 0;
   bit      stimulus_done = 1'b0;
   int      push_wait = 0;
   int      pop_wait = 0;

   // append one transaction to the stimulus queue
   function automatic void queue_req(req_type q);
      pending_reqs = {pending_reqs, q};
   endfunction

   function automatic int slot_at(int r, int i);
      return (hist_head[r] + i) % SLOTS;
   endfunction

   function automatic void store_sample(int r, int s, req_type q);
      hist_time[r][s] = q.stamp;
      hist_val[r][s][0] = q.pos_x;
      hist_val[r][s][1] = q.pos_y;
      hist_val[r][s][2] = q.pos_z;
      hist_val[r][s][3] = q.scl_x;
      hist_val[r][s][4] = q.scl_y;
      hist_val[r][s][5] = q.scl_z;
   endfunction

   // append a sample, emptying on a step back in time and trimming to the window
   function automatic void record_sample(int r, req_type q);
      logic [STAMP_W-1:0] newest, cut;
      logic [WIN_W-1:0] win;
      int ns;
      if (hist_fill[r] > 0) begin
         ns = slot_at(r, hist_fill[r] - 1);
         if (q.stamp < hist_time[r][ns]) begin
            hist_head[r] = 0;
            hist_fill[r] = 0;
         end else if (q.stamp == hist_time[r][ns]) begin
            store_sample(r, ns, q);
            return;
         end
      end
      if (hist_fill[r] >= SLOTS) begin
         hist_head[r] = (hist_head[r] + 1) % SLOTS;
         hist_fill[r] = SLOTS - 1;
      end
      store_sample(r, slot_at(r, hist_fill[r]), q);
      hist_fill[r]++;
      if (hist_fill[r] < 2) return;
      newest = hist_time[r][slot_at(r, hist_fill[r] - 1)];
      win = window_shadow[r < 4 ? r : 3];
      if ({8'd0, win} > newest) return;
      cut = newest - win;
      while (hist_fill[r] >= 2 && hist_time[r][slot_at(r, 1)] <= cut) begin
         hist_head[r] = (hist_head[r] + 1) % SLOTS;
         hist_fill[r]--;
      end
   endfunction

   // floor((b-a)*f/65536) added to a, at 32 bits
   function automatic logic [VAL_W-1:0] blend(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                               longint f);
      longint sa, sb, prod, q;
      sa = longint'($signed(a));
      sb = longint'($signed(b));
      prod = (sb - sa) * f;
      q = prod >>> 16;
      return VAL_W'(sa + q);
   endfunction

   function automatic rsp_type read_at(int r, logic [STAMP_W-1:0] t);
      rsp_type res;
      int lo, hi, mid, sa, sb, k;
      logic [STAMP_W-1:0] ta, tb;
      logic [STAMP_W+16:0] f;
      logic [VAL_W-1:0] vals [NUM_VALS];
      res = '0;
      if (hist_fill[r] == 0) return res;
      if (t > hist_time[r][slot_at(r, hist_fill[r] - 1)] ||
          t < hist_time[r][slot_at(r, 0)]) return res;
      res.ok = 1'b1;
      res.out_stamp = t;
      lo = 0;
      hi = hist_fill[r] - 1;
      if (t == hist_time[r][slot_at(r, hi)]) begin
         lo = hi;
      end else begin
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (hist_time[r][slot_at(r, mid)] < t) lo = mid + 1;
            else hi = mid;
         end
      end
      sb = slot_at(r, lo);
      if (lo == 0 || t == hist_time[r][sb]) begin
         for (k = 0; k < NUM_VALS; k++) vals[k] = hist_val[r][sb][k];
      end else begin
         sa = slot_at(r, lo - 1);
         ta = hist_time[r][sa];
         tb = hist_time[r][sb];
         if (tb > ta) begin
            f = ({17'd0, t - ta} << 16) / (tb - ta);
            if (f > 65536) f = 65536;
         end else begin
            f = 65536;
         end
         for (k = 0; k < NUM_VALS; k++)
            vals[k] = blend(hist_val[r][sa][k], hist_val[r][sb][k], longint'(f));
      end
      res.out_pos_x = vals[0];
      res.out_pos_y = vals[1];
      res.out_pos_z = vals[2];
      res.out_scl_x = vals[3];
      res.out_scl_y = vals[4];
      res.out_scl_z = vals[5];
      return res;
   endfunction

   function automatic rsp_type predict_history(req_type q);
      rsp_type res;
      int k;
      res = '0;
      case (q.cmd)
         CMD_CLEAR: begin
            for (k = 0; k < RINGS; k++) begin
               hist_head[k] = 0;
               hist_fill[k] = 0;
            end
            res.ok = 1'b1;
         end
         CMD_RECORD: begin
            if (q.ring_sel < RINGS) begin
               record_sample(q.ring_sel, q);
               res.ok = 1'b1;
            end
         end
         CMD_READ: begin
            if (q.ring_sel < RINGS) res = read_at(q.ring_sel, q.stamp);
         end
         default: ;
      endcase
      return res;
   endfunction

   // driver: pushes pending transactions with random gaps, predicts on acceptance
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            expected_rsps = {expected_rsps, predict_history(req_payload)};
            void'(pending_reqs.pop_front());
            push_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            if (pending_reqs.size() > 0 && $urandom_range(0, 3) == 0)
               req_payload <= pending_reqs[0];
            else
               push <= 1'b0;
         end else if (!push) begin
            if (push_wait > 0) begin
               push_wait <= push_wait - 1;
            end else if (pending_reqs.size() > 0) begin
               push <= 1'b1;
               req_payload <= pending_reqs[0];
            end
         end
      end
   end

   // monitor: random pop stalls, compare each response with the oldest expectation
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_payload);
               errors++;
            end else begin
               if (expected_rsps[0] !== rsp_payload) begin
                  $display("%0t: mismatch expected %h actual %h", $time,
                           expected_rsps[0], rsp_payload);
                  errors++;
               end
               void'(expected_rsps.pop_front());
            end
            pop_wait <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
            pop <= 1'b0;
         end else if (pop_wait > 0) begin
            pop_wait <= pop_wait - 1;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   function automatic req_type make_req(logic [1:0] c, int r, logic [STAMP_W-1:0] t);
      req_type q;
      q.cmd = c;
      q.ring_sel = 3'(r);
      q.stamp = t;
      q.pos_x = $urandom; q.pos_y = $urandom; q.pos_z = $urandom;
      q.scl_x = $urandom; q.scl_y = $urandom; q.scl_z = $urandom;
      return q;
   endfunction

   function automatic logic [STAMP_W-1:0] rand_stamp();
      return {$urandom, $urandom};
   endfunction

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || push || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (2 * 6 + 60) @(posedge clock);
   endtask

   task automatic write_window(int idx, logic [WIN_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CFG_IDX_W'(idx);
      csr_wdata <= v;
      window_shadow[idx] = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // random burst: mostly monotonic records and reads near the newest time
   task automatic random_phase(int count, logic [STAMP_W-1:0] step_max);
      logic [STAMP_W-1:0] now [RINGS];
      logic [STAMP_W-1:0] t;
      int r, pick;
      req_type q;
      for (int k = 0; k < RINGS; k++) now[k] = $urandom_range(0, 1000);
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, RINGS - 1);
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 9) == 0) t = now[r];
            else t = now[r] + $urandom_range(1, int'(step_max));
            now[r] = t;
            q = make_req(CMD_RECORD, r, t);
         end else if (pick < 85) begin
            t = now[r] - $urandom_range(0, int'(step_max) * 8);
            if (t > now[r]) t = 0;
            q = make_req(CMD_READ, r, t);
         end else if (pick < 88) begin
            now[r] = $urandom_range(0, 500);
            q = make_req(CMD_RECORD, r, now[r]);
         end else if (pick < 90) begin
            q = make_req(CMD_CLEAR, $urandom_range(0, 7), rand_stamp());
         end else if (pick < 93) begin
            q = make_req(2'($urandom_range(0, 1)), $urandom_range(RINGS, 7), rand_stamp());
         end else if (pick < 95) begin
            q = make_req(2'd3, $urandom_range(0, 7), rand_stamp());
         end else begin
            q = make_req(CMD_READ, r, rand_stamp());
         end
         queue_req(q);
      end
   endtask

   initial begin
      req_type q;
      for (int k = 0; k < RINGS; k++) begin
         hist_head[k] = 0;
         hist_fill[k] = 0;
      end
      for (int k = 0; k < NUM_CFG; k++) window_shadow[k] = WINDOW_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: every command, bounds, equal time, time going back, bad rings
      write_window(0, 40'd1);
      write_window(1, {WIN_W{1'b1}});
      write_window(2, 40'd100);
      write_window(3, 40'd5000);
      queue_req(make_req(CMD_READ, 0, 0));
      queue_req(make_req(CMD_RECORD, 1, 0));
      queue_req(make_req(CMD_RECORD, 1, 48'd1000));
      queue_req(make_req(CMD_READ, 1, 48'd500));
      queue_req(make_req(CMD_READ, 1, 48'd1000));
      queue_req(make_req(CMD_READ, 1, 0));
      queue_req(make_req(CMD_READ, 1, 48'd1001));
      queue_req(make_req(CMD_RECORD, 1, 48'd1000));
      queue_req(make_req(CMD_READ, 1, 48'd999));
      queue_req(make_req(CMD_RECORD, 1, 48'd10));
      queue_req(make_req(CMD_READ, 1, 48'd10));
      queue_req(make_req(CMD_RECORD, 0, 48'd5));
      queue_req(make_req(CMD_RECORD, 0, 48'd6));
      queue_req(make_req(CMD_RECORD, 0, 48'd7));
      queue_req(make_req(CMD_READ, 0, 48'd5));
      queue_req(make_req(CMD_RECORD, 2, {STAMP_W{1'b1}} - 1));
      queue_req(make_req(CMD_RECORD, 2, {STAMP_W{1'b1}}));
      queue_req(make_req(CMD_READ, 2, {STAMP_W{1'b1}}));
      queue_req(make_req(CMD_RECORD, 4, 48'd1));
      queue_req(make_req(CMD_READ, 7, 48'd1));
      queue_req(make_req(2'd3, 0, 48'd1));
      queue_req(make_req(CMD_CLEAR, 7, 0));
      queue_req(make_req(CMD_READ, 1, 48'd10));
      wait_idle();

      // ring overflow: more than the slot count with a wide window
      for (int n = 0; n < SLOTS + 10; n++)
         queue_req(make_req(CMD_RECORD, 1, 48'(n * 3 + 1)));
      queue_req(make_req(CMD_READ, 1, 48'd31));
      queue_req(make_req(CMD_READ, 1, 48'd1));
      wait_idle();

      // random phases under several window settings, extremes included
      random_phase(RANDOM_ITEMS / 4, 48'd200);
      wait_idle();
      for (int k = 0; k < NUM_CFG; k++) write_window(k, 40'($urandom_range(1, 3000)));
      random_phase(RANDOM_ITEMS / 4, 48'd400);
      wait_idle();
      for (int k = 0; k < NUM_CFG; k++)
         write_window(k, (k % 2) ? {WIN_W{1'b1}} : 40'd1);
      random_phase(RANDOM_ITEMS / 4, 48'd50);
      wait_idle();
      for (int k = 0; k < NUM_CFG; k++) write_window(k, WINDOW_RESET);
      random_phase(RANDOM_ITEMS / 4, 48'd60000);
      wait_idle();

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
